// ===== hdl/cswrs_pkg.sv =====
// Shared types and constants of the CSR segment weighted row sum block.
// Used by cswrs_mac and csr_segment_weighted_row_sum; depends on nothing.
`default_nettype none

package cswrs_pkg;

  // Field widths fixed by the interface
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int VAL_W     = 16;
  localparam int ENT_IDX_W = 8;
  localparam int SEG_W     = 7;
  localparam int PTR_W     = 9;
  localparam int CNT_W     = 7;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = 40;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'd1;

  localparam logic [CNT_W-1:0] COL_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] SEG_COUNT_RST = 7'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_DENSE   = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_POINTER = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_e;

  // One word of the entry memory: referenced dense row and its weight
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] coef;
  } ent_word_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic load;   // operands valid, form a product
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/cswrs_mac.sv =====
// Multiply-accumulate unit: registered Q8.8 x Q8.8 product, then a 40-bit
// wrapping accumulator. Depends on cswrs_pkg.
`default_nettype none

module cswrs_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cswrs_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [cswrs_pkg::VAL_W-1:0]  coef_i,
  input  logic signed [cswrs_pkg::VAL_W-1:0]  elem_i,
  output logic signed [cswrs_pkg::ACC_W-1:0]  acc_o,
  output logic                                busy_o
);
  import cswrs_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= coef_i * elem_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.load;
      acc_q      <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

`default_nettype wire

// ===== hdl/csr_segment_weighted_row_sum.sv =====
// CSR sparse-times-dense row combiner, top level. Depends on cswrs_pkg and
// cswrs_mac.
//
// Load requests fill three on-chip memories: the dense matrix (Q8.8, one word
// per row and column), the entry list (row reference plus Q8.8 coefficient)
// and the segment pointer table. A compute request names one segment and
// returns one Q24.16 sum per column in use (col_count, zero read as one and
// capped at MAX_COLS), with last set on the final one. Inactive segments and
// empty ranges return zeros. A compute reads the start and end pointers
// through the single pointer read port, then each column streams its entries
// through the entry memory, the dense memory and the multiply-accumulate unit
// at one entry per cycle, drains that pipeline and hands the sum to the output
// register. An empty or reversed range streams no entries, and an inactive
// segment also skips the pointer reads. Stalls on the result side hold back
// each column's hand-off. Memories power up unknown and hold no valid bits;
// every location must be written before a compute reads it.
`default_nettype none

module csr_segment_weighted_row_sum #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_SEGS    = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [cswrs_pkg::KIND_W-1:0]           kind_i,
  input  logic [cswrs_pkg::ROW_W-1:0]            row_index_i,
  input  logic [cswrs_pkg::COL_W-1:0]            col_index_i,
  input  logic signed [cswrs_pkg::VAL_W-1:0]     matrix_value_i,
  input  logic [cswrs_pkg::ENT_IDX_W-1:0]        entry_index_i,
  input  logic signed [cswrs_pkg::VAL_W-1:0]     coef_value_i,
  input  logic [cswrs_pkg::SEG_W-1:0]            seg_index_i,
  input  logic [cswrs_pkg::PTR_W-1:0]            pointer_value_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [cswrs_pkg::COL_W-1:0]            out_col_o,
  output logic signed [cswrs_pkg::ACC_W-1:0]     out_value_o,
  output logic                                   last_o,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [cswrs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cswrs_pkg::CNT_W-1:0]            cfg_data_i
);
  import cswrs_pkg::*;

  localparam int DENSE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int DenseAw = (DENSE_DEPTH > 1) ? $clog2(DENSE_DEPTH) : 1;
  localparam int EntAw   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PtrAw   = $clog2(MAX_SEGS + 1);
  localparam int IdxW    = $clog2(MAX_ENTRIES + 1);
  localparam int ColW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PTR_A,
    ST_PTR_B,
    ST_RUN
  } state_e;

  // Clamp a stored pointer to the end of the entry list
  function automatic logic [IdxW-1:0] ptr_sat(input logic [PTR_W-1:0] p);
    logic [IdxW-1:0] r;
    if (32'(p) > MAX_ENTRIES) begin
      r = IdxW'(MAX_ENTRIES);
    end else begin
      r = IdxW'(p);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers; the port never pushes back
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] col_count_q, seg_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= COL_COUNT_RST;
      seg_count_q <= SEG_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COL_COUNT: col_count_q <= cfg_data_i;
        CFG_SEG_COUNT: seg_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  state_e           state_q;
  logic             in_accept;
  kind_e            kind;
  logic             seg_active;
  logic [CNT_W-1:0] ncol;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign kind       = kind_e'(kind_i);

  // Segments past the configured count, or past the table, read as empty
  assign seg_active = (32'(seg_index_i) < 32'(seg_count_q)) &&
                      (32'(seg_index_i) < MAX_SEGS);

  // Zero columns act as one, too many act as the full row
  always_comb begin
    if (col_count_q == '0) begin
      ncol = CNT_W'(1);
    end else if (32'(col_count_q) > MAX_COLS) begin
      ncol = CNT_W'(MAX_COLS);
    end else begin
      ncol = col_count_q;
    end
  end

  // ---------------------------------------------------------------------
  // Memories: one write port (load requests), one registered read port
  // ---------------------------------------------------------------------
  logic signed [VAL_W-1:0] dense_mem [DENSE_DEPTH];
  ent_word_t               ent_mem   [MAX_ENTRIES];
  logic [PTR_W-1:0]        ptr_mem   [MAX_SEGS + 1];

  logic                    dense_we, ent_we, ptr_we;
  logic [DenseAw-1:0]      dense_wr_addr, dense_rd_addr;
  logic [EntAw-1:0]        ent_rd_addr;
  logic [PtrAw-1:0]        ptr_rd_addr;
  logic signed [VAL_W-1:0] dense_rd_q;
  ent_word_t               ent_rd_q;
  ent_word_t               ent_wr;
  logic [PTR_W-1:0]        ptr_rd_q;

  logic [SEG_W-1:0]        seg_q;
  logic [IdxW-1:0]         idx_q, start_q, end_q;
  logic [ColW-1:0]         col_q;

  assign dense_we = in_accept && (kind == KIND_DENSE) &&
                    (32'(row_index_i) < MAX_ROWS) && (32'(col_index_i) < MAX_COLS);
  assign ent_we   = in_accept && (kind == KIND_ENTRY) &&
                    (32'(entry_index_i) < MAX_ENTRIES);
  assign ptr_we   = in_accept && (kind == KIND_POINTER) &&
                    (32'(seg_index_i) <= MAX_SEGS);

  assign dense_wr_addr = DenseAw'(32'(row_index_i) * MAX_COLS + 32'(col_index_i));
  assign ent_wr.row    = row_index_i;
  assign ent_wr.coef   = coef_value_i;

  // Start pointer is read as the request is taken, the end pointer in ST_PTR_A
  assign ptr_rd_addr = (state_q == ST_IDLE) ? PtrAw'(seg_index_i)
                                            : PtrAw'(8'(seg_q) + 8'd1);
  assign ent_rd_addr   = EntAw'(idx_q);
  assign dense_rd_addr = DenseAw'(32'(ent_rd_q.row) * MAX_COLS + 32'(col_q));

  always_ff @(posedge clk_i) begin
    if (dense_we) begin
      dense_mem[dense_wr_addr] <= matrix_value_i;
    end
    dense_rd_q <= dense_mem[dense_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[EntAw'(entry_index_i)] <= ent_wr;
    end
    ent_rd_q <= ent_mem[ent_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[PtrAw'(seg_index_i)] <= pointer_value_i;
    end
    ptr_rd_q <= ptr_mem[ptr_rd_addr];
  end

  // ---------------------------------------------------------------------
  // Entry pipeline: issue entry read, then dense read, then MAC
  // ---------------------------------------------------------------------
  logic                    ent_vld_q;    // ent_rd_q holds a live entry
  logic                    dense_vld_q;  // dense_rd_q holds a live element
  logic signed [VAL_W-1:0] coef_q;
  logic                    issue, row_ok, col_done, col_last;
  logic [CNT_W-1:0]        ncol_q;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] mac_acc;
  mac_ctrl_t               mac_ctrl;

  logic                    out_valid_q, last_q;
  logic [COL_W-1:0]        out_col_q;
  logic signed [ACC_W-1:0] out_value_q;

  assign issue    = (state_q == ST_RUN) && (idx_q < end_q);
  // Rows past the dense matrix contribute nothing
  assign row_ok   = 32'(ent_rd_q.row) < MAX_ROWS;
  assign col_last = (32'(col_q) + 32'd1) == 32'(ncol_q);
  // Column finishes once the pipeline is empty and the output slot is free
  assign col_done = (state_q == ST_RUN) && !issue && !ent_vld_q && !dense_vld_q &&
                    !mac_busy && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    coef_q <= ent_rd_q.coef;
  end

  assign mac_ctrl.clear = (in_accept && (kind == KIND_COMPUTE)) || col_done;
  assign mac_ctrl.load  = dense_vld_q;

  cswrs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_q),
    .elem_i (dense_rd_q),
    .acc_o  (mac_acc),
    .busy_o (mac_busy)
  );

  // ---------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= '0;
      idx_q       <= '0;
      start_q     <= '0;
      end_q       <= '0;
      col_q       <= '0;
      ncol_q      <= '0;
      ent_vld_q   <= 1'b0;
      dense_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_col_q   <= '0;
      out_value_q <= '0;
      last_q      <= 1'b0;
    end else begin
      // hold a result until the sink takes it; load a new one as a column completes
      out_valid_q <= col_done || (out_valid_q && out_stall_i);
      // advance the entry pipeline; issue only happens while running
      ent_vld_q   <= issue;
      dense_vld_q <= ent_vld_q && row_ok;

      case (state_q)
        ST_IDLE: begin
          if (in_accept && (kind == KIND_COMPUTE)) begin
            seg_q  <= seg_index_i;
            ncol_q <= ncol;
            col_q  <= '0;
            if (seg_active) begin
              state_q <= ST_PTR_A;
            end else begin
              // inactive segment: empty range, zeros for every column
              start_q <= '0;
              end_q   <= '0;
              idx_q   <= '0;
              state_q <= ST_RUN;
            end
          end
        end
        ST_PTR_A: begin
          start_q <= ptr_sat(ptr_rd_q);
          idx_q   <= ptr_sat(ptr_rd_q);
          state_q <= ST_PTR_B;
        end
        ST_PTR_B: begin
          end_q   <= ptr_sat(ptr_rd_q);
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          if (col_done) begin
            out_col_q   <= COL_W'(col_q);
            out_value_q <= mac_acc;
            last_q      <= col_last;
            if (col_last) begin
              state_q <= ST_IDLE;
            end else begin
              // rewind to the segment start for the next column
              col_q <= col_q + 1'b1;
              idx_q <= start_q;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
